[rtl/ldse_pkg.sv]
// Shared types and constants for the lattice diffusion step engine.
// No dependencies.
`default_nettype none

package ldse_pkg;

  localparam int POP_BITS     = 16;
  localparam int WEIGHT_SHIFT = 16;
  localparam int MIX_W        = 17;
  localparam int LEN_W        = 9;
  localparam int IDX_W        = 8;
  localparam int DENS_W       = POP_BITS + 1;
  localparam int PROD_W       = POP_BITS + MIX_W + 2;

  localparam logic [MIX_W-1:0] WEIGHT_ONE    = MIX_W'(1 << WEIGHT_SHIFT);
  localparam logic [MIX_W-1:0] MIX_RESET     = MIX_W'(32768);
  localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(200);
  localparam logic [LEN_W-1:0] LEN_LIMIT_MAX = LEN_W'((1 << LEN_W) - 1);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_MIX = 1'b0;
  localparam logic REG_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_STEP_RUN,
    ST_STEP_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/lattice_diffusion_step_engine_unit.sv]
// D1Q2 lattice-Boltzmann diffusion engine: top level, stream and APB ports.
// Depends on ldse_pkg and ldse_ram.
`default_nettype none

// Ring of up to MAX_CELLS cells, each with a right- and a left-moving Q0.16
// population held in two RAMs. After reset a clearing pass zeroes both RAMs;
// no item is taken meanwhile. Write items and unused ops go from idle straight
// to finish, read items pass a read-wait state, and a step item the run and
// drain states (none on an empty ring): the step streams every active cell once
// through the RAM read port, one cell per cycle, collides it and writes the
// results straight to their advected places. Every item returns one transfer;
// a finished result waits in the output register while the next item is taken,
// and an item whose result is ready waits in the finish state while the
// previous result is still held by m_tready.

module lattice_diffusion_step_engine_unit #(
  parameter int MAX_CELLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: cell_index[7:0], right_value[23:8], left_value[39:24]
  input  wire logic [39:0] s_tdata,
  // s_tuser: op[1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: density[16:0], right_out[32:17], left_out[48:33], zero pad
  output logic [55:0]      m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int PB = ldse_pkg::POP_BITS;
  localparam int LW = ldse_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_LEN =
    (MAX_CELLS > ((1 << LW) - 1)) ? ldse_pkg::LEN_LIMIT_MAX : LW'(MAX_CELLS);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_CELLS - 1);

  ldse_pkg::state_t state, state_next;

  logic [ldse_pkg::MIX_W-1:0]  mix_weight;
  logic [LW-1:0]               cells_in_use;
  logic [AW-1:0]               clr_cnt;
  logic [LW-1:0]               rd_cnt;
  logic                        v1, v2;
  logic [LW-1:0]               i1, i2;
  logic signed [ldse_pkg::PROD_W-1:0] prod;
  logic [PB-1:0]               r2, l2, wrap_hold;
  logic                        hit_q;
  logic [ldse_pkg::DENS_W-1:0] res_density;
  logic [PB-1:0]               res_right, res_left;

  logic [LW-1:0]               len;
  logic [ldse_pkg::MIX_W-1:0]  weight;
  logic                        s_accept, idx_hit, out_free;
  logic [1:0]                  in_op;
  logic [ldse_pkg::IDX_W-1:0]  in_idx;
  logic [PB-1:0]               in_right, in_left;
  logic [PB-1:0]               r_rd, l_rd, new_r, new_l;
  logic signed [PB:0]          diff;
  logic signed [ldse_pkg::PROD_W-1:0] acc_r, acc_l;
  logic [LW-1:0]               r_dst, l_dst;

  logic          r_we, l_we;
  logic [AW-1:0] r_waddr, l_waddr, raddr;
  logic [PB-1:0] r_wdata, l_wdata;

  ldse_ram #(.WIDTH(PB), .DEPTH(MAX_CELLS)) u_right_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(raddr), .rdata(r_rd)
  );

  ldse_ram #(.WIDTH(PB), .DEPTH(MAX_CELLS)) u_left_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(raddr), .rdata(l_rd)
  );

  assign pready   = 1'b1;
  assign len      = (cells_in_use > MAX_LEN) ? MAX_LEN : cells_in_use;
  assign weight   = (mix_weight > ldse_pkg::WEIGHT_ONE) ? ldse_pkg::WEIGHT_ONE : mix_weight;
  assign s_accept = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign in_idx   = s_tdata[7:0];
  assign in_right = s_tdata[23:8];
  assign in_left  = s_tdata[39:24];
  assign idx_hit  = {1'b0, in_idx} < len;
  assign out_free = !m_tvalid || m_tready;

  // collision: own*w + other*(1-w) = other*2^16 + w*(own-other)
  assign diff  = $signed({1'b0, r_rd}) - $signed({1'b0, l_rd});
  assign acc_r = $signed({3'b000, l2, {ldse_pkg::WEIGHT_SHIFT{1'b0}}}) + prod;
  assign acc_l = $signed({3'b000, r2, {ldse_pkg::WEIGHT_SHIFT{1'b0}}}) - prod;
  assign new_r = acc_r[ldse_pkg::WEIGHT_SHIFT +: PB];
  assign new_l = acc_l[ldse_pkg::WEIGHT_SHIFT +: PB];
  assign r_dst = (i2 == len - LW'(1)) ? '0 : i2 + LW'(1);
  assign l_dst = i2 - LW'(1);

  always_comb begin
    prdata = {{(32 - ldse_pkg::MIX_W){1'b0}}, mix_weight};
    case (paddr[2])
      ldse_pkg::REG_LEN: prdata = {{(32 - LW){1'b0}}, cells_in_use};
      default:           prdata = {{(32 - ldse_pkg::MIX_W){1'b0}}, mix_weight};
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ldse_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = ldse_pkg::ST_IDLE;
      end
      ldse_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (in_op == ldse_pkg::OP_READ) begin
            state_next = ldse_pkg::ST_READ_WAIT;
          end else if (in_op == ldse_pkg::OP_STEP && len != '0) begin
            state_next = ldse_pkg::ST_STEP_RUN;
          end else begin
            state_next = ldse_pkg::ST_FINISH;
          end
        end
      end
      ldse_pkg::ST_READ_WAIT: state_next = ldse_pkg::ST_FINISH;
      ldse_pkg::ST_STEP_RUN: begin
        if (rd_cnt == len - LW'(1)) state_next = ldse_pkg::ST_STEP_DRAIN;
      end
      ldse_pkg::ST_STEP_DRAIN: begin
        if (!v1 && !v2) state_next = ldse_pkg::ST_FINISH;
      end
      ldse_pkg::ST_FINISH: begin
        if (out_free) state_next = ldse_pkg::ST_IDLE;
      end
      default: state_next = ldse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    r_we     = 1'b0;
    l_we     = 1'b0;
    r_waddr  = AW'(r_dst);
    l_waddr  = AW'(l_dst);
    r_wdata  = new_r;
    l_wdata  = new_l;
    raddr    = AW'(rd_cnt);
    unique case (state)
      ldse_pkg::ST_CLEAR: begin
        r_we    = 1'b1;
        l_we    = 1'b1;
        r_waddr = clr_cnt;
        l_waddr = clr_cnt;
        r_wdata = '0;
        l_wdata = '0;
      end
      ldse_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        raddr    = AW'(in_idx);
        r_waddr  = AW'(in_idx);
        l_waddr  = AW'(in_idx);
        r_wdata  = in_right;
        l_wdata  = in_left;
        if (s_accept && in_op == ldse_pkg::OP_WRITE && idx_hit) begin
          r_we = 1'b1;
          l_we = 1'b1;
        end
      end
      ldse_pkg::ST_STEP_RUN, ldse_pkg::ST_STEP_DRAIN: begin
        if (v2) begin
          r_we = 1'b1;
          l_we = (i2 != '0);
        end else if (state == ldse_pkg::ST_STEP_DRAIN && !v1) begin
          // left population of the first cell wraps to the last
          l_we    = 1'b1;
          l_waddr = AW'(len - LW'(1));
          l_wdata = wrap_hold;
        end
      end
      ldse_pkg::ST_READ_WAIT, ldse_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ldse_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      mix_weight   <= ldse_pkg::MIX_RESET;
      cells_in_use <= ldse_pkg::LEN_RESET;
      m_tvalid     <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      wrap_hold    <= '0;
    end else begin
      state <= state_next;
      if (state == ldse_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          ldse_pkg::REG_MIX: mix_weight   <= pwdata[ldse_pkg::MIX_W-1:0];
          default:           cells_in_use <= pwdata[LW-1:0];
        endcase
      end
      v1 <= (state == ldse_pkg::ST_STEP_RUN);
      v2 <= v1;
      if (v2 && i2 == '0) wrap_hold <= new_l;
      if (state == ldse_pkg::ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i1   <= rd_cnt;
    i2   <= i1;
    r2   <= r_rd;
    l2   <= l_rd;
    prod <= $signed({1'b0, weight}) * diff;
    if (state == ldse_pkg::ST_IDLE) begin
      rd_cnt <= '0;
    end else if (state == ldse_pkg::ST_STEP_RUN) begin
      rd_cnt <= rd_cnt + LW'(1);
    end
    if (s_accept) begin
      hit_q       <= idx_hit && in_op == ldse_pkg::OP_READ;
      res_density <= '0;
      res_right   <= '0;
      res_left    <= '0;
    end else if (state == ldse_pkg::ST_READ_WAIT && hit_q) begin
      res_density <= {1'b0, r_rd} + {1'b0, l_rd};
      res_right   <= r_rd;
      res_left    <= l_rd;
    end
    if (state == ldse_pkg::ST_FINISH && out_free) begin
      m_tdata <= {7'b0, res_left, res_right, res_density};
    end
  end

endmodule

`default_nettype wire

[rtl/ldse_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ldse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ldse_checker.sv]
// Port-level checker for lattice_diffusion_step_engine_unit, with its bind.
// Depends on the top level's port list only.
`default_nettype none

module ldse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic [39:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready
);

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken during clearing pass");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // density is the sum of both populations, padding zero
  a_density_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] == ({1'b0, m_tdata[32:17]} + {1'b0, m_tdata[48:33]}))
                 && (m_tdata[55:49] == 7'd0))
    else $error("density does not match populations");

endmodule

bind lattice_diffusion_step_engine_unit ldse_checker u_ldse_checker (.*);

`default_nettype wire

[dv/tb_lattice_diffusion_step_engine_unit.sv]
// Testbench for the D1Q2 lattice diffusion step engine: a stream driver and monitor
// with random idling, APB register writes and an item-level ring predictor.
// Depends on ldse_pkg and the lattice_diffusion_step_engine_unit RTL.
`timescale 1ns / 100ps

module tb_lattice_diffusion_step_engine_unit;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RING_MAX = 256;
  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [15:0] rv;
    logic [15:0] lv;
  } cell_cmd_t;

  typedef struct packed {
    logic [16:0] dens;
    logic [15:0] rout;
    logic [15:0] lout;
  } cell_reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lattice_diffusion_step_engine_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ring shadow and register copies
  logic [15:0]                ring_right [RING_MAX];
  logic [15:0]                ring_left  [RING_MAX];
  logic [ldse_pkg::MIX_W-1:0] cfg_mix = ldse_pkg::MIX_RESET;
  logic [ldse_pkg::LEN_W-1:0] cfg_len = ldse_pkg::LEN_RESET;

  cell_cmd_t   cell_cmd_q[$];
  cell_reply_t reply_q[$];
  cell_cmd_t   in_flight;
  int          src_idle = 0;
  int          snk_stall = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < RING_MAX; i++) begin
      ring_right[i] = '0;
      ring_left[i]  = '0;
    end
  end

  function automatic int ring_len();
    return (cfg_len > RING_MAX) ? RING_MAX : int'(cfg_len);
  endfunction

  // applies one command to the shadow ring and returns the reply it causes
  function automatic cell_reply_t predict_cell_reply(cell_cmd_t c);
    int          n;
    logic [63:0] w, r, l;
    logic [15:0] rc[RING_MAX];
    logic [15:0] lc[RING_MAX];
    cell_reply_t res;
    n = ring_len();
    res = '0;
    w = (cfg_mix > ldse_pkg::WEIGHT_ONE) ? 64'(ldse_pkg::WEIGHT_ONE) : 64'(cfg_mix);
    case (c.op)
      ldse_pkg::OP_WRITE: begin
        if (int'(c.idx) < n) begin
          ring_right[c.idx] = c.rv;
          ring_left[c.idx]  = c.lv;
        end
      end
      ldse_pkg::OP_STEP: begin
        if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            r = 64'(ring_right[i]);
            l = 64'(ring_left[i]);
            rc[i] = 16'((w * r + (64'd65536 - w) * l) >> ldse_pkg::WEIGHT_SHIFT);
            lc[i] = 16'((w * l + (64'd65536 - w) * r) >> ldse_pkg::WEIGHT_SHIFT);
          end
          for (int i = 0; i < n; i++) begin
            ring_right[(i + 1) % n]   = rc[i];
            ring_left[(i + n - 1) % n] = lc[i];
          end
        end
      end
      ldse_pkg::OP_READ: begin
        if (int'(c.idx) < n) begin
          res.rout = ring_right[c.idx];
          res.lout = ring_left[c.idx];
          res.dens = 17'(ring_right[c.idx]) + 17'(ring_left[c.idx]);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // stream source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_idle = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid)
        reply_q.push_back(predict_cell_reply(in_flight));
      if (src_idle > 0) begin
        src_idle--;
        s_tvalid <= 1'b0;
      end else if (cell_cmd_q.size() != 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          src_idle = $urandom_range(0, 7);
          s_tvalid <= 1'b0;
        end else begin
          in_flight = cell_cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= in_flight.op;
          s_tdata  <= {in_flight.lv, in_flight.rv, in_flight.idx};
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string tag, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
    end
  endtask

  // result sink and checker
  always @(posedge clk) begin
    cell_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer, expected none, got %h", $time, m_tdata);
        end else begin
          want = reply_q.pop_front();
          check_field("density", want.dens, m_tdata[16:0]);
          check_field("right_out", want.rout, m_tdata[32:17]);
          check_field("left_out", want.lout, m_tdata[48:33]);
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_stall = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic regsel, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (regsel == ldse_pkg::REG_MIX)
      cfg_mix = val[ldse_pkg::MIX_W-1:0];
    else
      cfg_len = val[ldse_pkg::LEN_W-1:0];
  endtask

  task automatic drain();
    while (cell_cmd_q.size() != 0 || s_tvalid || reply_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic [7:0] idx,
                          input logic [15:0] rv, input logic [15:0] lv);
    cell_cmd_t c;
    c.op = op;
    c.idx = idx;
    c.rv = rv;
    c.lv = lv;
    cell_cmd_q.push_back(c);
  endtask

  function automatic logic [15:0] pick_pop();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic gen_random(input int count);
    int          n;
    int unsigned sel;
    logic [1:0]  op;
    logic [7:0]  idx;
    n = ring_len();
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)
        op = ldse_pkg::OP_WRITE;
      else if (sel < 75)
        op = ldse_pkg::OP_READ;
      else if (sel < 93)
        op = ldse_pkg::OP_STEP;
      else
        op = OP_SPARE;
      if (n > 0 && $urandom_range(0, 99) < 85)
        idx = 8'($urandom_range(0, n - 1));
      else
        idx = 8'($urandom());
      push_cmd(op, idx, pick_pop(), pick_pop());
    end
  endtask

  task automatic run_phase(input logic [31:0] mix, input logic [31:0] len, input int count);
    drain();
    cfg_write(ldse_pkg::REG_MIX, mix);
    cfg_write(ldse_pkg::REG_LEN, len);
    gen_random(count);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: weight one half, 200 cells
    push_cmd(ldse_pkg::OP_WRITE, 8'd0, 16'hFFFF, 16'h0000);
    push_cmd(ldse_pkg::OP_WRITE, 8'd199, 16'h0000, 16'hFFFF);
    push_cmd(ldse_pkg::OP_WRITE, 8'd200, 16'h1234, 16'h5678);
    push_cmd(ldse_pkg::OP_WRITE, 8'd255, 16'hFFFF, 16'hFFFF);
    push_cmd(ldse_pkg::OP_READ, 8'd0, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd199, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd200, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd255, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_cmd(ldse_pkg::OP_STEP, 8'd0, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd0, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd1, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd198, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd199, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_WRITE, 8'd5, 16'hFFFF, 16'hFFFF);
    push_cmd(ldse_pkg::OP_READ, 8'd5, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_STEP, 8'hAA, 16'h5555, 16'hAAAA);
    push_cmd(ldse_pkg::OP_READ, 8'd4, 16'h0000, 16'h0000);
    push_cmd(ldse_pkg::OP_READ, 8'd6, 16'h0000, 16'h0000);
    push_cmd(OP_SPARE, 8'd0, 16'h0000, 16'h0000);
    gen_random(60);

    run_phase(32'd65536, 32'd256, 110);
    run_phase(32'd0, 32'd2, 80);
    // weight above one on a ring of one
    run_phase(32'd131071, 32'd1, 40);
    // empty ring
    run_phase(32'd40000, 32'd0, 25);
    // ring longer than the store
    run_phase(32'($urandom_range(1, 65535)), 32'd511, 100);
    run_phase(32'($urandom_range(0, 65536)), 32'($urandom_range(2, 256)), 110);
    run_phase(32'd65535, 32'd3, 70);
    drain();
    calm = 1'b1;
    run_phase(32'd1, 32'($urandom_range(100, 256)), 110);

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ldse_pkg.sv
rtl/ldse_ram.sv
rtl/lattice_diffusion_step_engine_unit.sv
rtl/ldse_checker.sv
dv/tb_lattice_diffusion_step_engine_unit.sv
